/* sv/rpe_pkg.sv */
// rpe_pkg: shared types and constants of the reprojection error filter
// holds payload words, command and status groups, register indexes
// no dependencies
package rpe_pkg;

    localparam int MAX_CAMERAS      = 16;
    localparam int MAX_TRACK        = 64;
    localparam int WORDS_PER_CAMERA = 21;
    localparam int CAM_WORDS        = MAX_CAMERAS * WORDS_PER_CAMERA;
    localparam int CAM_AW           = $clog2(CAM_WORDS);
    localparam int CAM_IW           = $clog2(MAX_CAMERAS);
    localparam int TRACK_W          = 7;
    localparam int ACC_W            = 50;
    localparam int SUM_W            = 48;
    localparam int DIV_NW           = 48;
    localparam int DIV_DW           = 32;
    localparam int DIV_CW           = $clog2(DIV_NW + 1);
    localparam int SQ_W             = 64;
    localparam int SQ_CW            = $clog2(SQ_W / 2 + 1);

    localparam logic [4:0]  WORD_T0   = 5'd9;
    localparam logic [4:0]  WORD_K0   = 5'd12;
    localparam logic [4:0]  WORD_REG  = 5'd21;
    localparam logic [31:0] PENALTY   = 32'd65470464;

    localparam logic [1:0] REG_ERROR_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TRACK_MINIMUM = 2'd1;
    localparam logic [1:0] REG_CAMERA_COUNT  = 2'd2;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_LOAD    = 1'b1;

    typedef struct packed {
        logic               func;
        logic [3:0]         camera_index;
        logic [4:0]         word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] key_u;
        logic signed [31:0] key_v;
        logic               key_valid;
        logic               last_observation;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        mean_error;
        logic [TRACK_W-1:0] track_len;
        logic               keep;
    } out_word_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD_WORD, ACC_SET_PROD, ACC_ADD
    } acc_mode_t;

    typedef enum logic [1:0] {
        MUL_P, MUL_C, MUL_DU, MUL_DV
    } mul_op_t;

    typedef enum logic [1:0] {
        DIV_U, DIV_V, DIV_MEAN
    } div_sel_t;

    typedef struct packed {
        logic       capture;
        logic       mem_wr;
        logic       track_inc;
        logic       rd_en;
        logic [4:0] word;
        logic       mul_en;
        mul_op_t    mul_op;
        logic [1:0] idx;
        acc_mode_t  acc_mode;
        logic       store_c;
        logic       store_q;
        logic       div_start;
        div_sel_t   div_sel;
        logic       store_u;
        logic       store_v;
        logic       sq_load;
        logic       sq_add;
        logic       sqrt_start;
        logic       err_sqrt;
        logic       err_pen;
        logic       sum_add;
        logic       mean_pen;
        logic       store_mean;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic obs_valid;
        logic acc_pos;
        logic acc_zero;
        logic div_busy;
        logic sqrt_busy;
        logic last;
        logic valid_nz;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/rpe_div.sv */
// rpe_div: restoring unsigned divider, one quotient bit per cycle
// depends on rpe_pkg
module rpe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rpe_pkg::DIV_NW-1:0] dividend,
    input  logic [rpe_pkg::DIV_DW-1:0] divisor,
    output logic                       busy,
    output logic [rpe_pkg::DIV_NW-1:0] quotient
);
    import rpe_pkg::*;

    logic              busy_reg, busy_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW:0]   rem_sh;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_NW);
            quo_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/rpe_sqrt.sv */
// rpe_sqrt: integer square root, two radicand bits per cycle
// depends on rpe_pkg
module rpe_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rpe_pkg::SQ_W-1:0] radicand,
    output logic                     busy,
    output logic [31:0]              root
);
    import rpe_pkg::*;

    logic             busy_reg, busy_next;
    logic [SQ_CW-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]  n_reg, n_next;
    logic [SQ_W-1:0]  res_reg, res_next;
    logic [SQ_W-1:0]  bit_reg, bit_next;
    logic [SQ_W-1:0]  trial;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = SQ_CW'(SQ_W / 2);
            n_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(SQ_W - 2){1'b0}}};
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SQ_CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

/* sv/rpe_dp.sv */
// rpe_dp: datapath with camera table, multiply-accumulate, divider, square root
// depends on rpe_pkg, rpe_div, rpe_sqrt
module rpe_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rpe_pkg::dp_cmd_t            cmd,
    output rpe_pkg::dp_status_t         status,
    input  rpe_pkg::in_word_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rpe_pkg::out_word_t          m_data,
    input  logic [31:0]                 error_limit,
    input  logic [rpe_pkg::TRACK_W-1:0] track_minimum,
    input  logic [4:0]                  camera_count
);
    import rpe_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed(ACC_W'(32'sh7fffffff))) begin
            r = 32'sh7fffffff;
        end else if (x < -$signed(ACC_W'(64'h80000000))) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] quo_signed(input logic [DIV_NW-1:0] mag,
                                                     input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (mag > DIV_NW'(64'h80000000)) begin
                r = 32'sh80000000;
            end else begin
                r = -$signed(mag[31:0]);
            end
        end else begin
            if (mag > DIV_NW'(64'h7fffffff)) begin
                r = 32'sh7fffffff;
            end else begin
                r = mag[31:0];
            end
        end
        return r;
    endfunction

    in_word_t            in_reg;
    logic [31:0]         mem [CAM_WORDS];
    logic [31:0]         rdata_reg;
    logic [MAX_CAMERAS-1:0] flag_reg;
    logic signed [63:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]  c_reg [3];
    logic signed [31:0]  q_reg [3];
    logic signed [31:0]  u_reg, v_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [31:0]         err_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TRACK_W-1:0]  valid_reg, track_reg;
    logic [31:0]         mean_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;

    logic [3:0]          cam;
    logic                cam_ok;
    logic [CAM_AW-1:0]   cam_base, wr_addr, rd_addr;
    logic signed [31:0]  p_arr [3];
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  prod_sh;
    logic signed [31:0]  du, dv;
    logic [32:0]         q0_abs, q1_abs, q2_abs;
    logic [DIV_NW-1:0]   div_n;
    logic [DIV_DW-1:0]   div_d;
    logic                div_busy, sqrt_busy;
    logic [DIV_NW-1:0]   div_q;
    logic [31:0]         root;
    logic [SUM_W:0]      sum_wide;
    logic                keep;

    assign cam      = in_reg.camera_index;
    assign cam_ok   = int'(cam) < MAX_CAMERAS;
    assign cam_base = CAM_AW'(cam) * CAM_AW'(WORDS_PER_CAMERA);
    assign wr_addr  = cam_base + CAM_AW'(in_reg.word_index);
    assign rd_addr  = cam_base + CAM_AW'(cmd.word);
    assign p_arr[0] = in_reg.point_x;
    assign p_arr[1] = in_reg.point_y;
    assign p_arr[2] = in_reg.point_z;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.mem_wr && cam_ok && in_reg.word_index < WORD_REG) begin
            mem[wr_addr] <= in_reg.word_value;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        unique case (cmd.mul_op)
            MUL_P:   begin mul_a = rdata_reg; mul_b = p_arr[cmd.idx]; end
            MUL_C:   begin mul_a = rdata_reg; mul_b = c_reg[cmd.idx]; end
            MUL_DU:  begin mul_a = du;        mul_b = du;             end
            default: begin mul_a = dv;        mul_b = dv;             end
        endcase
    end

    assign prod_sh = prod_reg >>> 16;

    always_comb begin
        unique case (cmd.acc_mode)
            ACC_LOAD_WORD: acc_next = {{(ACC_W - 32){rdata_reg[31]}}, rdata_reg};
            ACC_SET_PROD:  acc_next = prod_sh[ACC_W-1:0];
            ACC_ADD:       acc_next = acc_reg + prod_sh[ACC_W-1:0];
            default:       acc_next = acc_reg;
        endcase
    end

    assign q0_abs = q_reg[0][31] ? -{1'b1, q_reg[0]} : {1'b0, q_reg[0]};
    assign q1_abs = q_reg[1][31] ? -{1'b1, q_reg[1]} : {1'b0, q_reg[1]};
    assign q2_abs = q_reg[2][31] ? -{1'b1, q_reg[2]} : {1'b0, q_reg[2]};

    always_comb begin
        unique case (cmd.div_sel)
            DIV_U:   begin div_n = {q0_abs[31:0], 16'h0}; div_d = q2_abs[31:0]; end
            DIV_V:   begin div_n = {q1_abs[31:0], 16'h0}; div_d = q2_abs[31:0]; end
            default: begin div_n = sum_reg; div_d = DIV_DW'(valid_reg); end
        endcase
    end

    rpe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    rpe_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (sq_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign du = sat32(ACC_W'(u_reg) - ACC_W'(in_reg.key_u));
    assign dv = sat32(ACC_W'(v_reg) - ACC_W'(in_reg.key_v));
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(err_reg);
    assign keep = (mean_reg <= error_limit) && (track_reg >= track_minimum);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        if (cmd.store_c) begin
            c_reg[cmd.idx] <= sat32(acc_reg);
        end
        if (cmd.store_q) begin
            q_reg[cmd.idx] <= sat32(acc_reg);
        end
        if (cmd.store_u) begin
            u_reg <= quo_signed(div_q, q_reg[0][31] ^ q_reg[2][31]);
        end
        if (cmd.store_v) begin
            v_reg <= quo_signed(div_q, q_reg[1][31] ^ q_reg[2][31]);
        end
        if (cmd.sq_load) begin
            sq_reg <= prod_reg;
        end else if (cmd.sq_add) begin
            sq_reg <= sq_reg + prod_reg;
        end
        if (cmd.err_sqrt) begin
            err_reg <= root;
        end else if (cmd.err_pen) begin
            err_reg <= PENALTY;
        end
        if (cmd.store_mean) begin
            mean_reg <= (div_q[DIV_NW-1:32] != '0) ? 32'hffffffff : div_q[31:0];
        end else if (cmd.mean_pen) begin
            mean_reg <= PENALTY;
        end
        if (cmd.out_load) begin
            m_data_reg.mean_error <= mean_reg;
            m_data_reg.track_len  <= track_reg;
            m_data_reg.keep       <= keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg    <= '0;
            sum_reg     <= '0;
            valid_reg   <= '0;
            track_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.mem_wr && cam_ok && in_reg.word_index == WORD_REG) begin
                flag_reg[cam[CAM_IW-1:0]] <= in_reg.word_value[0];
            end
            if (cmd.track_inc && track_reg < TRACK_W'(MAX_TRACK)) begin
                track_reg <= track_reg + 1'b1;
            end
            if (cmd.sum_add) begin
                sum_reg <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                if (valid_reg < TRACK_W'(MAX_TRACK)) begin
                    valid_reg <= valid_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                sum_reg     <= '0;
                valid_reg   <= '0;
                track_reg   <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.func      = in_reg.func;
    assign status.obs_valid = ({1'b0, cam} < camera_count) && cam_ok
                              && flag_reg[cam[CAM_IW-1:0]] && in_reg.key_valid;
    assign status.acc_pos   = !acc_reg[ACC_W-1] && (acc_reg != '0);
    assign status.acc_zero  = (acc_reg == '0);
    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign status.last      = in_reg.last_observation;
    assign status.valid_nz  = (valid_reg != '0);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/rpe_ctrl.sv */
// rpe_ctrl: sequencer for load and observation words
// depends on rpe_pkg
module rpe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output rpe_pkg::dp_cmd_t    cmd,
    input  rpe_pkg::dp_status_t status
);
    import rpe_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_DEC      = 21'h000002,
        S_RD       = 21'h000004,
        S_MUL      = 21'h000008,
        S_ACC      = 21'h000010,
        S_STO      = 21'h000020,
        S_DIVU_GO  = 21'h000040,
        S_DIVU_WT  = 21'h000080,
        S_DIVV_GO  = 21'h000100,
        S_DIVV_WT  = 21'h000200,
        S_SQ1      = 21'h000400,
        S_SQ2      = 21'h000800,
        S_SQ3      = 21'h001000,
        S_SQRT_GO  = 21'h002000,
        S_SQRT_WT  = 21'h004000,
        S_PEN      = 21'h008000,
        S_ADD      = 21'h010000,
        S_LAST     = 21'h020000,
        S_MEAN_GO  = 21'h040000,
        S_MEAN_WT  = 21'h080000,
        S_OUT      = 21'h100000
    } state_t;

    state_t     state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] term_reg, term_next;
    logic [4:0] row3;

    // phase 0: camera transform, phase 1: intrinsics
    assign row3 = 5'({3'b0, row_reg} * 5'd3);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.mul_op = MUL_P;
        cmd.acc_mode = ACC_HOLD;
        cmd.div_sel  = DIV_U;
        cmd.idx    = row_reg;
        s_ready    = 1'b0;
        if (!phase_reg) begin
            cmd.word = (term_reg == 2'd0) ? WORD_T0 + 5'(row_reg)
                                          : row3 + 5'(term_reg) - 5'd1;
        end else begin
            cmd.word = WORD_K0 + row3 + 5'(term_reg) - 5'd1;
        end
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                if (status.func == FUNC_LOAD) begin
                    cmd.mem_wr = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.track_inc = 1'b1;
                    if (status.obs_valid) begin
                        phase_next = 1'b0;
                        row_next   = 2'd0;
                        term_next  = 2'd0;
                        state_next = S_RD;
                    end else begin
                        state_next = S_LAST;
                    end
                end
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = (!phase_reg && term_reg == 2'd0) ? S_ACC : S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = phase_reg ? MUL_C : MUL_P;
                cmd.idx    = term_reg - 2'd1;
                state_next = S_ACC;
            end
            S_ACC: begin
                if (!phase_reg && term_reg == 2'd0) begin
                    cmd.acc_mode = ACC_LOAD_WORD;
                end else if (phase_reg && term_reg == 2'd1) begin
                    cmd.acc_mode = ACC_SET_PROD;
                end else begin
                    cmd.acc_mode = ACC_ADD;
                end
                if (term_reg == 2'd3) begin
                    state_next = S_STO;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_STO: begin
                cmd.store_c = !phase_reg;
                cmd.store_q = phase_reg;
                if (row_reg == 2'd2) begin
                    if (!phase_reg) begin
                        if (status.acc_pos) begin
                            phase_next = 1'b1;
                            row_next   = 2'd0;
                            term_next  = 2'd1;
                            state_next = S_RD;
                        end else begin
                            state_next = S_PEN;
                        end
                    end else begin
                        state_next = status.acc_zero ? S_PEN : S_DIVU_GO;
                    end
                end else begin
                    row_next   = row_reg + 2'd1;
                    term_next  = phase_reg ? 2'd1 : 2'd0;
                    state_next = S_RD;
                end
            end
            S_DIVU_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_U;
                state_next    = S_DIVU_WT;
            end
            S_DIVU_WT: begin
                if (!status.div_busy) begin
                    cmd.store_u = 1'b1;
                    state_next  = S_DIVV_GO;
                end
            end
            S_DIVV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_V;
                state_next    = S_DIVV_WT;
            end
            S_DIVV_WT: begin
                if (!status.div_busy) begin
                    cmd.store_v = 1'b1;
                    state_next  = S_SQ1;
                end
            end
            S_SQ1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DU;
                state_next = S_SQ2;
            end
            S_SQ2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = MUL_DV;
                cmd.sq_load = 1'b1;
                state_next  = S_SQ3;
            end
            S_SQ3: begin
                cmd.sq_add = 1'b1;
                state_next = S_SQRT_GO;
            end
            S_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_WT;
            end
            S_SQRT_WT: begin
                if (!status.sqrt_busy) begin
                    cmd.err_sqrt = 1'b1;
                    state_next   = S_ADD;
                end
            end
            S_PEN: begin
                cmd.err_pen = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD: begin
                cmd.sum_add = 1'b1;
                state_next  = S_LAST;
            end
            S_LAST: begin
                if (!status.last) begin
                    state_next = S_IDLE;
                end else if (status.valid_nz) begin
                    state_next = S_MEAN_GO;
                end else begin
                    cmd.mean_pen = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = S_MEAN_WT;
            end
            S_MEAN_WT: begin
                cmd.div_sel = DIV_MEAN;
                if (!status.div_busy) begin
                    cmd.store_mean = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            row_reg   <= 2'd0;
            term_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            term_reg  <= term_next;
        end
    end

endmodule

/* sv/reprojection_error_filter.sv */
// reprojection_error_filter: top level with configuration registers
// depends on rpe_pkg, rpe_ctrl, rpe_dp
//
// The block takes one word at a time. A valid observation that is not penalised
// runs the two matrix-vector products through one shared 32x32 multiplier and
// the table memory port, then the two projection divisions on the shared
// divider (one quotient bit per cycle, 48 bits) and then the square root (one
// result bit per cycle). The last observation of a point adds the mean division
// on the same divider. Results are held in an output register, so the next word
// is taken while a result waits.
module reprojection_error_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rpe_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rpe_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rpe_pkg::*;

    logic [31:0]        error_limit_reg;
    logic [TRACK_W-1:0] track_minimum_reg;
    logic [4:0]         camera_count_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_limit_reg   <= 32'd262144;
            track_minimum_reg <= TRACK_W'(2);
            camera_count_reg  <= 5'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_ERROR_LIMIT:   error_limit_reg   <= pwdata;
                REG_TRACK_MINIMUM: track_minimum_reg <= pwdata[TRACK_W-1:0];
                REG_CAMERA_COUNT:  camera_count_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ERROR_LIMIT:   prdata = error_limit_reg;
            REG_TRACK_MINIMUM: prdata = 32'(track_minimum_reg);
            REG_CAMERA_COUNT:  prdata = 32'(camera_count_reg);
            default:           prdata = 32'h0;
        endcase
    end

    assign pready = 1'b1;

    rpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    rpe_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .error_limit   (error_limit_reg),
        .track_minimum (track_minimum_reg),
        .camera_count  (camera_count_reg)
    );

endmodule
